FILE: sv/assert_macros.svh
// Assertion macros used by the checker file pwa_checker.sv.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define PWA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is checked during reset too
`define PWA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/pwa_pkg.sv
// Package for the perspective warp address block: register map, widths, reset values.
// Depends on nothing.
`default_nettype none

package pwa_pkg;

   localparam int COEF_W    = 64;  // coefficient width, signed fixed point
   localparam int FRAC_BITS = 32;  // fraction bits of the coefficients
   localparam int CFG_REGS  = 8;
   localparam int IDX_W     = 3;   // register index bits
   localparam int IDX_LSB   = 3;   // registers sit on 8-byte steps
   localparam int ADDR_W    = IDX_W + IDX_LSB;

   typedef logic [IDX_W-1:0] reg_idx_type;

   // register indexes
   localparam reg_idx_type REG_XX = 3'd0;
   localparam reg_idx_type REG_XY = 3'd1;
   localparam reg_idx_type REG_XT = 3'd2;
   localparam reg_idx_type REG_YX = 3'd3;
   localparam reg_idx_type REG_YY = 3'd4;
   localparam reg_idx_type REG_YT = 3'd5;
   localparam reg_idx_type REG_WX = 3'd6;
   localparam reg_idx_type REG_WY = 3'd7;

   typedef logic [COEF_W-1:0] coef_type;

   // identity matrix at reset
   localparam coef_type COEF_ONE = coef_type'(64'd1) << FRAC_BITS;
   localparam coef_type CFG_RESET [CFG_REGS] = '{
      COEF_ONE, '0, '0, '0, COEF_ONE, '0, '0, '0
   };

endpackage

`default_nettype wire

FILE: sv/perspective_warp_address.sv
// Perspective warp address generator: projective mapping of pixel coordinates.
// Depends on pwa_pkg.
`default_nettype none

// One coordinate word is taken per clock: busy stays low and start may be held
// high every cycle. Each word comes out on rsp_valid in order; the receiver
// cannot stall, so the pipeline never holds. The depth is set by the input
// register, the multiply stage, the affine sums, the magnitude and range
// stages, one restoring division step per quotient bit and the output register
// (both axes share the denominator and run side by side). The user must write
// coefficients over the register port only while no word is in flight; the
// block does not enforce this. Register i sits at byte address 8*i, 64 bits wide.
module perspective_warp_address import pwa_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire  [COORD_BITS-1:0] req_dest_x,
   input  wire  [COORD_BITS-1:0] req_dest_y,
   output logic                  rsp_valid,
   output logic [COORD_BITS-1:0] rsp_src_x,
   output logic [COORD_BITS-1:0] rsp_src_y,
   output logic                  rsp_outside,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire  [ADDR_W-1:0]     paddr,
   input  wire  [COEF_W-1:0]     pwdata,
   output logic [COEF_W-1:0]     prdata,
   output logic                  pready
);

   localparam int PW = COEF_W + COORD_BITS + 1;  // product width
   localparam int SW = PW + 1;                   // affine sum width
   localparam int DW = SW + COORD_BITS;          // shifted compare width
   localparam logic [SW-1:0] W_ONE = {{(SW-1){1'b0}}, 1'b1} << FRAC_BITS;

   // coefficient registers
   coef_type coef_ff [CFG_REGS];
   logic     csr_wr;
   reg_idx_type csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[ADDR_W-1:IDX_LSB];
   assign prdata  = coef_ff[csr_idx];
   assign busy    = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_REGS; i++) coef_ff[i] <= CFG_RESET[i];
      end else if (csr_wr) begin
         coef_ff[csr_idx] <= pwdata;
      end
   end

   // stage 0: input register
   logic                  v0_ff;
   logic [COORD_BITS-1:0] x0_ff, y0_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start;
      x0_ff <= req_dest_x;
      y0_ff <= req_dest_y;
   end

   // stage 1: six coefficient products
   logic                 v1_ff;
   logic signed [PW-1:0] p_ff [6];
   logic signed [PW-1:0] p_in [6];
   logic signed [COORD_BITS:0] xs, ys;

   assign xs = $signed({1'b0, x0_ff});
   assign ys = $signed({1'b0, y0_ff});

   always_comb begin
      p_in[0] = $signed(coef_ff[REG_XX]) * xs;
      p_in[1] = $signed(coef_ff[REG_XY]) * ys;
      p_in[2] = $signed(coef_ff[REG_YX]) * xs;
      p_in[3] = $signed(coef_ff[REG_YY]) * ys;
      p_in[4] = $signed(coef_ff[REG_WX]) * xs;
      p_in[5] = $signed(coef_ff[REG_WY]) * ys;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v0_ff;
      for (int i = 0; i < 6; i++) p_ff[i] <= p_in[i];
   end

   // stage 2: affine sums u, v, w
   logic                 v2_ff;
   logic signed [SW-1:0] u_ff, v_ff, w_ff;
   logic signed [SW-1:0] u_in, v_in, w_in;

   always_comb begin
      u_in = SW'(p_ff[0]) + SW'(p_ff[1]) + SW'($signed(coef_ff[REG_XT]));
      v_in = SW'(p_ff[2]) + SW'(p_ff[3]) + SW'($signed(coef_ff[REG_YT]));
      w_in = SW'(p_ff[4]) + SW'(p_ff[5]) + $signed(W_ONE);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      u_ff <= u_in;
      v_ff <= v_in;
      w_ff <= w_in;
   end

   // stage 3: magnitudes and quotient signs
   logic          v3_ff;
   logic [SW-1:0] mu_ff, mv_ff, mw_ff;
   logic          nu_ff, nv_ff, wz_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      mu_ff <= u_ff[SW-1] ? SW'(-u_ff) : SW'(u_ff);
      mv_ff <= v_ff[SW-1] ? SW'(-v_ff) : SW'(v_ff);
      mw_ff <= w_ff[SW-1] ? SW'(-w_ff) : SW'(w_ff);
      nu_ff <= u_ff[SW-1] ^ w_ff[SW-1];
      nv_ff <= v_ff[SW-1] ^ w_ff[SW-1];
      wz_ff <= (w_ff == '0);
   end

   // stage 4 and division steps; index 0 is the range check stage
   logic                  dv_ff  [COORD_BITS+1];
   logic                  bad_ff [COORD_BITS+1];
   logic [SW-1:0]         ru_ff  [COORD_BITS+1];
   logic [SW-1:0]         rv_ff  [COORD_BITS+1];
   logic [SW-1:0]         den_ff [COORD_BITS+1];
   logic [COORD_BITS-1:0] qu_ff  [COORD_BITS+1];
   logic [COORD_BITS-1:0] qv_ff  [COORD_BITS+1];

   // a ratio is out of range if its magnitude reaches one and it is
   // negative, or if it reaches 2^COORD_BITS
   logic [DW-1:0] lim;
   logic          bad_u, bad_v;

   always_comb begin
      lim   = DW'(mw_ff) << COORD_BITS;
      bad_u = (mu_ff >= mw_ff) && (nu_ff || DW'(mu_ff) >= lim);
      bad_v = (mv_ff >= mw_ff) && (nv_ff || DW'(mv_ff) >= lim);
   end

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else       dv_ff[0] <= v3_ff;
      bad_ff[0] <= wz_ff | bad_u | bad_v;
      ru_ff[0]  <= mu_ff;
      rv_ff[0]  <= mv_ff;
      den_ff[0] <= mw_ff;
      qu_ff[0]  <= '0;
      qv_ff[0]  <= '0;
   end

   // restoring division, one quotient bit per stage, MSB first
   for (genvar k = 0; k < COORD_BITS; k++) begin : g_div
      localparam int SH = COORD_BITS - 1 - k;
      logic [DW-1:0]         trial;
      logic                  ge_u, ge_v;
      logic [SW-1:0]         ru_in, rv_in;
      logic [COORD_BITS-1:0] qu_in, qv_in;

      always_comb begin
         trial = DW'(den_ff[k]) << SH;
         ge_u  = DW'(ru_ff[k]) >= trial;
         ge_v  = DW'(rv_ff[k]) >= trial;
         ru_in = ge_u ? SW'(DW'(ru_ff[k]) - trial) : ru_ff[k];
         rv_in = ge_v ? SW'(DW'(rv_ff[k]) - trial) : rv_ff[k];
         qu_in = qu_ff[k] | (ge_u ? COORD_BITS'(1) << SH : '0);
         qv_in = qv_ff[k] | (ge_v ? COORD_BITS'(1) << SH : '0);
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[k+1] <= 1'b0;
         else       dv_ff[k+1] <= dv_ff[k];
         bad_ff[k+1] <= bad_ff[k];
         den_ff[k+1] <= den_ff[k];
         ru_ff[k+1]  <= ru_in;
         rv_ff[k+1]  <= rv_in;
         qu_ff[k+1]  <= qu_in;
         qv_ff[k+1]  <= qv_in;
      end
   end

   // output register
   logic                  rsp_valid_ff, rsp_outside_ff;
   logic [COORD_BITS-1:0] rsp_src_x_ff, rsp_src_y_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= dv_ff[COORD_BITS];
      rsp_outside_ff <= bad_ff[COORD_BITS];
      rsp_src_x_ff   <= bad_ff[COORD_BITS] ? '0 : qu_ff[COORD_BITS];
      rsp_src_y_ff   <= bad_ff[COORD_BITS] ? '0 : qv_ff[COORD_BITS];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outside = rsp_outside_ff;
   assign rsp_src_x   = rsp_src_x_ff;
   assign rsp_src_y   = rsp_src_y_ff;

endmodule

`default_nettype wire

FILE: sv/pwa_checker.sv
// Port-level checker for perspective_warp_address, with its bind statement.
// Depends on pwa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pwa_checker import pwa_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input wire                  clock,
   input wire                  reset,
   input wire                  start,
   input wire                  busy,
   input wire                  rsp_valid,
   input wire [COORD_BITS-1:0] rsp_src_x,
   input wire [COORD_BITS-1:0] rsp_src_y,
   input wire                  rsp_outside,
   input wire [ADDR_W-1:0]     paddr
);

   // edges from the accepting edge to the one that samples the word
   localparam int LAT = COORD_BITS + 6;

   // every accepted word comes out after the fixed latency
   `PWA_ASSERT(a_latency, clock, reset, (start && !busy) |-> ##LAT rsp_valid, "word lost")

   // no word comes out without one taken before it
   `PWA_ASSERT(a_no_extra, clock, reset, rsp_valid |-> $past(start && !busy, LAT), "word invented")

   // a flagged word carries a zero coordinate
   `PWA_ASSERT(a_flag_zero, clock, reset,
      (rsp_valid && rsp_outside) |-> (rsp_src_x == '0 && rsp_src_y == '0), "flag with coordinate")

   // register address bus is never unknown outside reset, also while psel is low
   `PWA_ASSERT_ALWAYS(a_addr_known, clock, reset || !$isunknown(paddr), "address unknown")

endmodule

bind perspective_warp_address pwa_checker #(.COORD_BITS(COORD_BITS)) u_pwa_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_src_x   (rsp_src_x),
   .rsp_src_y   (rsp_src_y),
   .rsp_outside (rsp_outside),
   .paddr       (paddr)
);

`default_nettype wire
